### rtl/core/token_replay_table_top_defines.svh
// Assertion macros for the token replay table.
// Included by the top level; needs clk_i and rst_ni in the including scope.
`ifndef TOKEN_REPLAY_TABLE_TOP_DEFINES_SVH
`define TOKEN_REPLAY_TABLE_TOP_DEFINES_SVH

`ifndef SYNTH
// Check a property on every rising edge, skipped while reset is held
`define TRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("token replay table assertion failed");
// Check a property on every rising edge, reset included
`define TRT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("token replay table invariant failed");
`else
`define TRT_ASSERT(lbl, prop)
`define TRT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### rtl/core/trt_pkg.sv
// Shared types and constants of the token replay table.
// No dependencies; used by token_replay_table_top, token_replay_table_checker and tb.
package trt_pkg;

  // Default sizing
  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned TOKEN_BYTES_DEF   = 16;

  // Fixed field widths
  localparam int unsigned PROFILE_W = 32;
  localparam int unsigned ID_W      = 64;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 7;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPT  = 2'd0,
    ST_INVALID = 2'd1,
    ST_REPLAY  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Claim sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_DECIDE
  } state_e;

endpackage

### rtl/core/token_replay_table_top.sv
// Token replay table: a replay cache for one-time claims with expiry.
// Depends on trt_pkg and token_replay_table_top_defines.svh.
//
// A claim is taken when start_i is high and busy_o is low. The block then reads every
// table slot from one synchronous memory, one slot per cycle, checking for expiry and
// for a live match, and finally writes the claim into the lowest free slot if it is
// accepted. The result word shows on status_o and live_count_o for one cycle with
// done_o high, registered after the SCAN, FINISH and DECIDE states; the next claim can be
// taken in that same cycle. busy_o stays high from the accepting edge until DECIDE is left,
// so the slot scan through the single memory read port holds off a new claim.
// The receiver cannot stall: it must take the result word in the cycle done_o is high.
// Occupied slots always form a prefix of the table, so a fill count stands in for
// per-slot valid marks and reset needs no clearing pass.
`include "token_replay_table_top_defines.svh"

module token_replay_table_top #(
  parameter int unsigned TABLE_ENTRIES = trt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned TOKEN_BYTES   = trt_pkg::TOKEN_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [trt_pkg::PROFILE_W-1:0]  profile_i,
  input  logic [trt_pkg::ID_W-1:0]       principal_id_i,
  input  logic [63:0]                    token_lo_i,
  input  logic [63:0]                    token_hi_i,
  input  logic [trt_pkg::TIME_W-1:0]     expiry_time_i,
  input  logic [trt_pkg::TIME_W-1:0]     now_i,
  output logic                           done_o,
  output logic [trt_pkg::STATUS_W-1:0]   status_o,
  output logic [trt_pkg::COUNT_W-1:0]    live_count_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SUM_W = (CNT_W > trt_pkg::COUNT_W) ? CNT_W : trt_pkg::COUNT_W;
  localparam int unsigned TOK_W = 8 * TOKEN_BYTES;

  // Slot layout: {expiry, token, principal, profile}
  localparam int unsigned PROF_OFF = 0;
  localparam int unsigned PRIN_OFF = PROF_OFF + trt_pkg::PROFILE_W;
  localparam int unsigned TOK_OFF  = PRIN_OFF + trt_pkg::ID_W;
  localparam int unsigned EXP_OFF  = TOK_OFF + TOK_W;
  localparam int unsigned ENT_W    = EXP_OFF + trt_pkg::TIME_W;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'((1 << trt_pkg::COUNT_W) - 1);

  trt_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0] addr_q, addr_d;
  logic [IDX_W-1:0] chk_idx_q;
  logic             chk_vld_q, chk_vld_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             done_q, done_d;

  // Claim held for the scan
  logic [trt_pkg::PROFILE_W-1:0] prof_q;
  logic [trt_pkg::ID_W-1:0]      prin_q;
  logic [TOK_W-1:0]              tok_q;
  logic [trt_pkg::TIME_W-1:0]    exp_q;
  logic [trt_pkg::TIME_W-1:0]    now_q;
  logic [127:0]                  tok_in;

  // Scan results
  logic [CNT_W-1:0] live_cnt_q;
  logic             replay_q;
  logic             have_free_q;
  logic [IDX_W-1:0] free_idx_q;

  // Memory
  logic [ENT_W-1:0] mem_q [TABLE_ENTRIES];
  logic [ENT_W-1:0] rd_data_q;
  logic             mem_we;
  logic [ENT_W-1:0] wr_data;

  // Slot check
  logic                          slot_used;
  logic                          slot_live;
  logic                          slot_match;
  logic [trt_pkg::PROFILE_W-1:0] ent_prof;
  logic [trt_pkg::ID_W-1:0]      ent_prin;
  logic [TOK_W-1:0]              ent_tok;
  logic [trt_pkg::TIME_W-1:0]    ent_exp;

  // Decision
  logic                          accept;
  logic                          invalid;
  trt_pkg::status_e              status_d;
  trt_pkg::status_e              status_q;
  logic [CNT_W-1:0]              total_cnt;
  logic [SUM_W-1:0]              total_wide;
  logic [trt_pkg::COUNT_W-1:0]   count_d;
  logic [trt_pkg::COUNT_W-1:0]   count_q;

  logic start_acc;

  assign start_acc = start_i && (state_q == trt_pkg::S_IDLE);
  assign tok_in    = {token_hi_i, token_lo_i};

  // Split the slot word coming out of the memory
  assign ent_prof = rd_data_q[PROF_OFF +: trt_pkg::PROFILE_W];
  assign ent_prin = rd_data_q[PRIN_OFF +: trt_pkg::ID_W];
  assign ent_tok  = rd_data_q[TOK_OFF +: TOK_W];
  assign ent_exp  = rd_data_q[EXP_OFF +: trt_pkg::TIME_W];

  // Judge one slot against the held claim
  assign slot_used  = CNT_W'(chk_idx_q) < fill_q;
  assign slot_live  = slot_used && (ent_exp > now_q);
  assign slot_match = (ent_prof == prof_q) && (ent_prin == prin_q) && (ent_tok == tok_q);

  // Decide the outcome from the finished scan
  assign invalid = (prof_q == '0) || (prin_q == '0) || (exp_q <= now_q);
  always_comb begin
    if (invalid) begin
      status_d = trt_pkg::ST_INVALID;
    end else if (replay_q) begin
      status_d = trt_pkg::ST_REPLAY;
    end else if (!have_free_q) begin
      status_d = trt_pkg::ST_FULL;
    end else begin
      status_d = trt_pkg::ST_ACCEPT;
    end
  end
  assign accept     = (status_d == trt_pkg::ST_ACCEPT);
  assign total_cnt  = live_cnt_q + CNT_W'(accept);
  assign total_wide = SUM_W'(total_cnt);
  assign count_d    = (total_wide > COUNT_MAX) ? COUNT_MAX[trt_pkg::COUNT_W-1:0]
                                               : total_wide[trt_pkg::COUNT_W-1:0];
  assign wr_data    = {exp_q, tok_q, prin_q, prof_q};

  // Sequencer: next state and memory control
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    chk_vld_d = 1'b0;
    fill_d    = fill_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    case (state_q)
      trt_pkg::S_IDLE: begin
        if (start_i) begin
          addr_d  = '0;
          state_d = trt_pkg::S_SCAN;
        end
      end
      trt_pkg::S_SCAN: begin
        chk_vld_d = 1'b1;
        if (addr_q == LAST_IDX) begin
          state_d = trt_pkg::S_FINISH;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      trt_pkg::S_FINISH: begin
        state_d = trt_pkg::S_DECIDE;
      end
      trt_pkg::S_DECIDE: begin
        done_d  = 1'b1;
        mem_we  = accept;
        if (accept && (CNT_W'(free_idx_q) == fill_q)) begin
          fill_d = fill_q + 1'b1;
        end
        state_d = trt_pkg::S_IDLE;
      end
      default: begin
        state_d = trt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= trt_pkg::S_IDLE;
      addr_q    <= '0;
      chk_idx_q <= '0;
      chk_vld_q <= 1'b0;
      fill_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      chk_idx_q <= addr_q;
      chk_vld_q <= chk_vld_d;
      fill_q    <= fill_d;
      done_q    <= done_d;
    end
  end

  // Accumulate scan results; clear them when a claim is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_cnt_q  <= '0;
      replay_q    <= 1'b0;
      have_free_q <= 1'b0;
      free_idx_q  <= '0;
    end else if (start_acc) begin
      live_cnt_q  <= '0;
      replay_q    <= 1'b0;
      have_free_q <= 1'b0;
      free_idx_q  <= '0;
    end else if (chk_vld_q) begin
      if (slot_live) begin
        live_cnt_q <= live_cnt_q + 1'b1;
        if (slot_match) begin
          replay_q <= 1'b1;
        end
      end else if (!have_free_q) begin
        have_free_q <= 1'b1;
        free_idx_q  <= chk_idx_q;
      end
    end
  end

  // Hold the claim word for the whole scan
  always_ff @(posedge clk_i) begin
    if (start_acc) begin
      prof_q <= profile_i;
      prin_q <= principal_id_i;
      tok_q  <= tok_in[TOK_W-1:0];
      exp_q  <= expiry_time_i;
      now_q  <= now_i;
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (state_q == trt_pkg::S_DECIDE) begin
      status_q <= status_d;
      count_q  <= count_d;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[free_idx_q] <= wr_data;
    end
    rd_data_q <= mem_q[addr_q];
  end

  assign busy_o       = (state_q != trt_pkg::S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign live_count_o = count_q;

  // Checks
  `TRT_ASSERT(a_start_enters_scan, start_i && !busy_o |=> state_q == trt_pkg::S_SCAN)
  `TRT_ASSERT(a_done_follows_decide, done_o |-> $past(state_q == trt_pkg::S_DECIDE))
  `TRT_ASSERT(a_accept_counts_live, done_o && status_q == trt_pkg::ST_ACCEPT |-> live_count_o != '0)
  `TRT_ASSERT(a_fill_in_range, fill_q <= CNT_W'(TABLE_ENTRIES))

endmodule

### dv/token_replay_table_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the token replay table: watches claim and result words,
// predicts each result from its own slot table and compares them.
// Depends on trt_pkg.
module token_replay_table_checker
  import trt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned TOKEN_BYTES   = TOKEN_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_o,
  input  logic [PROFILE_W-1:0] profile_i,
  input  logic [ID_W-1:0]      principal_id_i,
  input  logic [63:0]          token_lo_i,
  input  logic [63:0]          token_hi_i,
  input  logic [TIME_W-1:0]    expiry_time_i,
  input  logic [TIME_W-1:0]    now_i,
  input  logic                 done_o,
  input  logic [STATUS_W-1:0]  status_o,
  input  logic [COUNT_W-1:0]   live_count_o,
  output int                   fail_cnt,
  output int                   pending_cnt
);

  typedef struct packed {
    status_e             status;
    logic [COUNT_W-1:0]  live_count;
  } claim_outcome_t;

  // Shadow copy of the slot table
  logic                 slot_used    [TABLE_ENTRIES];
  logic [PROFILE_W-1:0] slot_prof    [TABLE_ENTRIES];
  logic [ID_W-1:0]      slot_prin    [TABLE_ENTRIES];
  logic [63:0]          slot_tok_lo  [TABLE_ENTRIES];
  logic [63:0]          slot_tok_hi  [TABLE_ENTRIES];
  logic [TIME_W-1:0]    slot_exp     [TABLE_ENTRIES];

  claim_outcome_t outcome_q[$];
  claim_outcome_t oldest;
  int             errors = 0;

  assign fail_cnt = errors;

  // Keep only the low nbytes bytes of a 64-bit token half
  function automatic logic [63:0] byte_mask(input int nbytes);
    if (nbytes >= 8) return '1;
    if (nbytes <= 0) return '0;
    return (64'd1 << (8 * nbytes)) - 64'd1;
  endfunction

  // Judge one claim against the table and store it when accepted
  function automatic claim_outcome_t judge_claim(
    input logic [PROFILE_W-1:0] prof,
    input logic [ID_W-1:0]      prin,
    input logic [63:0]          tlo_raw,
    input logic [63:0]          thi_raw,
    input logic [TIME_W-1:0]    exp_t,
    input logic [TIME_W-1:0]    now_t
  );
    logic [63:0]    tlo;
    logic [63:0]    thi;
    logic           bad;
    logic           replay;
    logic           have_free;
    logic           live_slot;
    int unsigned    free_idx;
    int unsigned    live;
    claim_outcome_t res;
    tlo       = tlo_raw & byte_mask(int'(TOKEN_BYTES));
    thi       = thi_raw & byte_mask(int'(TOKEN_BYTES) - 8);
    bad       = (prof == '0) || (prin == '0) || (exp_t <= now_t);
    replay    = 1'b0;
    have_free = 1'b0;
    free_idx  = 0;
    live      = 0;
    // Scan: count live slots, look for a match, find the lowest free slot
    for (int i = 0; i < int'(TABLE_ENTRIES); i++) begin
      live_slot = slot_used[i] && (slot_exp[i] > now_t);
      if (live_slot) begin
        live++;
        if (slot_prof[i] == prof && slot_prin[i] == prin &&
            slot_tok_lo[i] == tlo && slot_tok_hi[i] == thi) begin
          replay = 1'b1;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_idx  = i;
      end
    end
    if (bad) begin
      res.status = ST_INVALID;
    end else if (replay) begin
      res.status = ST_REPLAY;
    end else if (!have_free) begin
      res.status = ST_FULL;
    end else begin
      slot_used[free_idx]   = 1'b1;
      slot_prof[free_idx]   = prof;
      slot_prin[free_idx]   = prin;
      slot_tok_lo[free_idx] = tlo;
      slot_tok_hi[free_idx] = thi;
      slot_exp[free_idx]    = exp_t;
      live++;
      res.status = ST_ACCEPT;
    end
    res.live_count = (live > 127) ? 7'd127 : live[COUNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(TABLE_ENTRIES); i++) slot_used[i] = 1'b0;
      outcome_q.delete();
      pending_cnt <= 0;
    end else begin
      // Compare the result word with the oldest prediction
      if (done_o) begin
        if (outcome_q.size() == 0) begin
          $error("result word with no claim pending: status %0d, live_count %0d",
                 status_o, live_count_o);
          errors++;
        end else begin
          oldest = outcome_q.pop_front();
          if (status_o !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, status_o);
            errors++;
          end
          if (live_count_o !== oldest.live_count) begin
            $error("live_count: expected %0d, actual %0d", oldest.live_count, live_count_o);
            errors++;
          end
        end
      end
      // Predict the result of a newly taken claim word
      if (start_i && !busy_o) begin
        outcome_q.push_back(judge_claim(profile_i, principal_id_i, token_lo_i,
                                        token_hi_i, expiry_time_i, now_i));
      end
      pending_cnt <= outcome_q.size();
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for token_replay_table_top: drives claim words with random idling and
// gives the verdict. Depends on trt_pkg, the top and token_replay_table_checker.
module tb;
  import trt_pkg::*;

  localparam int unsigned TABLE_ENTRIES  = TABLE_ENTRIES_DEF;
  localparam int unsigned TOKEN_BYTES    = TOKEN_BYTES_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_CLAIMS   = 670;
  localparam int unsigned HISTORY_DEPTH  = 48;
  localparam logic [63:0] TIME_MAX       = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [PROFILE_W-1:0] profile_i;
  logic [ID_W-1:0]      principal_id_i;
  logic [63:0]          token_lo_i;
  logic [63:0]          token_hi_i;
  logic [TIME_W-1:0]    expiry_time_i;
  logic [TIME_W-1:0]    now_i;
  logic                 done_o;
  logic [STATUS_W-1:0]  status_o;
  logic [COUNT_W-1:0]   live_count_o;
  int                   fail_cnt;
  int                   pending_cnt;

  typedef struct packed {
    logic [PROFILE_W-1:0] prof;
    logic [ID_W-1:0]      prin;
    logic [63:0]          tlo;
    logic [63:0]          thi;
  } claim_key_t;

  claim_key_t   sent_keys[$];
  logic [63:0]  t_now;
  int unsigned  life_max;
  int unsigned  life_choices[4] = '{6, 60, 250, 3000};
  int unsigned  quiet_cycles = 0;

  token_replay_table_top #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TOKEN_BYTES   (TOKEN_BYTES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .profile_i      (profile_i),
    .principal_id_i (principal_id_i),
    .token_lo_i     (token_lo_i),
    .token_hi_i     (token_hi_i),
    .expiry_time_i  (expiry_time_i),
    .now_i          (now_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .live_count_o   (live_count_o)
  );

  token_replay_table_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TOKEN_BYTES   (TOKEN_BYTES)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .profile_i      (profile_i),
    .principal_id_i (principal_id_i),
    .token_lo_i     (token_lo_i),
    .token_hi_i     (token_hi_i),
    .expiry_time_i  (expiry_time_i),
    .now_i          (now_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .live_count_o   (live_count_o),
    .fail_cnt       (fail_cnt),
    .pending_cnt    (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL token_replay_table_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Draw from a tiny pool now and then so that claims collide
  function automatic logic [63:0] pick_id();
    logic [63:0] v;
    v = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(1, 3)) : rand64();
    if (v == '0) v = 64'd1;
    return v;
  endfunction

  // Present one claim word and hold it until the block takes it
  task automatic send_claim(input logic [PROFILE_W-1:0] prof, input logic [ID_W-1:0] prin,
                            input logic [63:0] tlo, input logic [63:0] thi,
                            input logic [TIME_W-1:0] exp_t, input logic [TIME_W-1:0] now_t);
    start_i        <= 1'b1;
    profile_i      <= prof;
    principal_id_i <= prin;
    token_lo_i     <= tlo;
    token_hi_i     <= thi;
    expiry_time_i  <= exp_t;
    now_i          <= now_t;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Drop start for a random gap, pct times in a hundred
  task automatic idle_sender(input int unsigned pct);
    if ($urandom_range(0, 99) < pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk_i);
    end
  endtask

  // Hold off until every taken claim has its result
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  // One random claim: mostly well-formed against a moving clock, plus replays,
  // near misses, invalid claims, backward time and full-range noise
  task automatic send_random_claim(input int unsigned idle_pct);
    claim_key_t  key;
    logic [63:0] exp_t;
    logic [63:0] now_t;
    int unsigned roll;
    logic        keep;
    roll = $urandom_range(0, 99);
    if (roll >= 95) t_now = t_now + 64'($urandom_range(1, 60));
    key.prof = 32'(pick_id());
    if (key.prof == '0) key.prof = 32'd1;
    key.prin = pick_id();
    key.tlo  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 3)) : rand64();
    key.thi  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 3)) : rand64();
    now_t    = t_now;
    exp_t    = t_now + 64'($urandom_range(1, life_max));
    keep     = 1'b1;
    if (roll < 30 && sent_keys.size() != 0) begin
      // Replay an earlier claim, sometimes with one bit flipped
      key = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
      if ($urandom_range(0, 3) == 0) begin
        key = key ^ claim_key_t'(224'(1) << $urandom_range(0, $bits(claim_key_t) - 1));
      end
    end else if (roll < 40) begin
      case ($urandom_range(0, 2))
        0:       key.prof = '0;
        1:       key.prin = '0;
        default: exp_t = now_t - 64'($urandom_range(0, 4));
      endcase
      keep = 1'b0;
    end else if (roll < 45) begin
      // Noise; expiry stays below the clock base so these slots die off
      key.prof = $urandom();
      key.prin = rand64();
      key.tlo  = rand64();
      key.thi  = rand64();
      now_t    = rand64();
      exp_t    = rand64() >> 1;
      keep     = 1'b0;
    end else if (roll < 50) begin
      // Look back in time so that expired slots count as live again
      now_t = t_now - 64'($urandom_range(1, 400));
      exp_t = now_t + 64'($urandom_range(1, life_max));
    end
    send_claim(key.prof, key.prin, key.tlo, key.thi, exp_t, now_t);
    if (keep) begin
      sent_keys.push_back(key);
      if (sent_keys.size() > HISTORY_DEPTH) void'(sent_keys.pop_front());
    end
    t_now = t_now + 64'($urandom_range(0, 3));
    idle_sender(idle_pct);
  endtask

  initial begin
    int unsigned idle_plan[3];
    logic [63:0] t0;
    idle_plan      = '{20, 76, 0};
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    profile_i      = '0;
    principal_id_i = '0;
    token_lo_i     = '0;
    token_hi_i     = '0;
    expiry_time_i  = '0;
    now_i          = '0;
    t_now          = {2'b10, 30'($urandom()), $urandom()};
    life_max       = 60;
    t0             = t_now;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each invalid cause, extremes, replay, near miss, slot reuse
    send_claim('0, 64'd5, 64'd1, 64'd2, t0 + 64'd10, t0);
    send_claim(32'd5, '0, 64'd1, 64'd2, t0 + 64'd10, t0);
    send_claim(32'd5, 64'd5, 64'd1, 64'd2, t0, t0);
    send_claim(32'd5, 64'd5, 64'd1, 64'd2, t0 - 64'd1, t0);
    send_claim('1, '1, '1, '1, TIME_MAX, '0);
    send_claim('1, '1, '1, '1, TIME_MAX, '0);
    send_claim('1, '1, '1, ~(64'd1 << 63), TIME_MAX, '0);
    send_claim(32'd1, 64'd1, '0, '0, t0 + 64'd5, t0);
    send_claim(32'd1, 64'd1, '0, '0, t0 + 64'd5, t0 + 64'd4);
    send_claim(32'd1, 64'd1, '0, '0, t0 + 64'd9, t0 + 64'd5);
    send_claim(32'd2, 64'd1, '0, '0, 64'd1, '0);
    send_claim(32'd2, 64'd1, '0, '0, TIME_MAX, TIME_MAX - 64'd1);
    send_claim(32'd3, 64'd3, 64'd3, 64'd3, TIME_MAX, TIME_MAX);
    send_claim('0, '0, '0, '0, '0, '0);
    drain_results();

    // Random phases, the table carried over; let everything settle in between
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < int'(PHASE_CLAIMS); n++) begin
        if (n % 64 == 0) life_max = life_choices[$urandom_range(0, 3)];
        send_random_claim(idle_plan[phase]);
      end
      drain_results();
    end

    repeat (TABLE_ENTRIES + 8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS token_replay_table_top");
    end else begin
      $display("FAIL token_replay_table_top");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/trt_pkg.sv
rtl/core/token_replay_table_top.sv
dv/token_replay_table_checker.sv
dv/tb.sv
